@@ rtl/eesd_pkg.sv @@
`timescale 1ns / 1ps

package eesd_pkg;

    typedef enum logic [1:0] {
        MODE_BYTE    = 2'd0,
        MODE_ARG_END = 2'd1,
        MODE_CMD_END = 2'd2,
        MODE_UNUSED  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_ESCAPE = 2'd1,
        PH_OCTAL  = 2'd2,
        PH_SILENT = 2'd3
    } t_phase;

    typedef enum logic {
        CFG_BSD_STYLE    = 1'b0,
        CFG_ALERT_ENABLE = 1'b1
    } t_cfg_reg;

    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_7         = 8'h37;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_C         = 8'h63;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_V         = 8'h76;
    localparam logic [7:0] CODE_BELL    = 8'h07;
    localparam logic [7:0] CODE_BS      = 8'h08;
    localparam logic [7:0] CODE_TAB     = 8'h09;
    localparam logic [7:0] CODE_VT      = 8'h0B;
    localparam logic [7:0] CODE_FF      = 8'h0C;
    localparam logic [7:0] CODE_CR      = 8'h0D;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // Up to three output bytes produced by one input item
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
    } t_bundle;

endpackage

@@ rtl/eesd_front.sv @@
`timescale 1ns / 1ps

module eesd_front import eesd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_bundle              o_bundle
);

    logic   r_bsd;
    logic   r_alert;
    t_phase r_phase;
    t_phase n_phase;
    logic [7:0] r_oval;
    logic [7:0] n_oval;
    logic [1:0] r_ocnt;
    logic [1:0] n_ocnt;
    logic       r_first;
    logic       n_first;
    logic [1:0] r_held;
    logic [1:0] n_held;
    logic       r_supp;
    logic       n_supp;
    logic [1:0] r_bia;
    logic [1:0] n_bia;

    t_bundle    bd;
    logic [7:0] d;
    logic [7:0] oct_next;
    logic       accept;

    function automatic t_bundle put_byte(input t_bundle b_in, input logic [7:0] x);
        t_bundle res;
        res = b_in;
        res.bytes[res.count] = x;
        res.count = res.count + 2'd1;
        return res;
    endfunction

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept && (bd.count != 2'd0);
    assign o_bundle   = bd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsd   <= 1'b0;
            r_alert <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IDX_W'(CFG_BSD_STYLE)) begin
                r_bsd <= i_cfg_data;
            end else if (i_cfg_index == CFG_IDX_W'(CFG_ALERT_ENABLE)) begin
                r_alert <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
            r_oval  <= '0;
            r_ocnt  <= '0;
            r_first <= 1'b1;
            r_held  <= '0;
            r_supp  <= 1'b0;
            r_bia   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_oval  <= n_oval;
            r_ocnt  <= n_ocnt;
            r_first <= n_first;
            r_held  <= n_held;
            r_supp  <= n_supp;
            r_bia   <= n_bia;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_oval   = r_oval;
        n_ocnt   = r_ocnt;
        n_first  = r_first;
        n_held   = r_held;
        n_supp   = r_supp;
        n_bia    = r_bia;
        bd       = '0;
        d        = i_in_data.data_byte;
        oct_next = {r_oval[4:0], d[2:0]};

        case (i_in_data.mode)
            MODE_BYTE: begin
                if (r_bsd) begin
                    if (r_first && r_held == r_bia && r_bia < 2'd2 &&
                        d == ((r_bia == 2'd0) ? CH_DASH : CH_N)) begin
                        n_held = r_held + 2'd1;
                    end else begin
                        if (r_held >= 2'd1) bd = put_byte(bd, CH_DASH);
                        if (r_held >= 2'd2) bd = put_byte(bd, CH_N);
                        n_held = '0;
                        bd = put_byte(bd, d);
                    end
                    if (r_bia != 2'd3) n_bia = r_bia + 2'd1;
                end else begin
                    case (r_phase)
                        PH_NORMAL: begin
                            if (d == CH_BACKSLASH) n_phase = PH_ESCAPE;
                            else bd = put_byte(bd, d);
                        end
                        PH_OCTAL: begin
                            if (d inside {[CH_0:CH_7]}) begin
                                if (r_ocnt == 2'd2) begin
                                    bd      = put_byte(bd, oct_next);
                                    n_phase = PH_NORMAL;
                                    n_oval  = '0;
                                    n_ocnt  = '0;
                                end else begin
                                    n_oval = oct_next;
                                    n_ocnt = r_ocnt + 2'd1;
                                end
                            end else begin
                                bd      = put_byte(bd, r_oval);
                                n_phase = PH_NORMAL;
                                n_oval  = '0;
                                n_ocnt  = '0;
                                if (d == CH_BACKSLASH) n_phase = PH_ESCAPE;
                                else bd = put_byte(bd, d);
                            end
                        end
                        PH_ESCAPE: begin
                            n_phase = PH_NORMAL;
                            case (d)
                                CH_B:         bd = put_byte(bd, CODE_BS);
                                CH_F:         bd = put_byte(bd, CODE_FF);
                                CH_N:         bd = put_byte(bd, CH_NEWLINE);
                                CH_R:         bd = put_byte(bd, CODE_CR);
                                CH_T:         bd = put_byte(bd, CODE_TAB);
                                CH_V:         bd = put_byte(bd, CODE_VT);
                                CH_BACKSLASH: bd = put_byte(bd, CH_BACKSLASH);
                                CH_C:         n_phase = PH_SILENT;
                                CH_0: begin
                                    n_phase = PH_OCTAL;
                                    n_oval  = '0;
                                    n_ocnt  = '0;
                                end
                                CH_A: begin
                                    if (r_alert) begin
                                        bd = put_byte(bd, CODE_BELL);
                                    end else begin
                                        bd = put_byte(bd, CH_BACKSLASH);
                                        bd = put_byte(bd, d);
                                    end
                                end
                                default: begin
                                    bd = put_byte(bd, CH_BACKSLASH);
                                    bd = put_byte(bd, d);
                                end
                            endcase
                        end
                        default: begin
                        end
                    endcase
                end
            end
            MODE_ARG_END, MODE_CMD_END: begin
                if (r_bsd) begin
                    if (r_first && r_held == 2'd2 && r_bia == 2'd2) begin
                        n_supp = 1'b1;
                    end else begin
                        if (r_held >= 2'd1) bd = put_byte(bd, CH_DASH);
                        if (r_held >= 2'd2) bd = put_byte(bd, CH_N);
                        if (i_in_data.mode == MODE_ARG_END) bd = put_byte(bd, CH_SPACE);
                        else if (!r_supp) bd = put_byte(bd, CH_NEWLINE);
                    end
                end else if (r_phase != PH_SILENT) begin
                    if (r_phase == PH_ESCAPE) bd = put_byte(bd, CH_BACKSLASH);
                    else if (r_phase == PH_OCTAL) bd = put_byte(bd, r_oval);
                    bd = put_byte(bd, (i_in_data.mode == MODE_ARG_END) ? CH_SPACE
                                                                      : CH_NEWLINE);
                    n_phase = PH_NORMAL;
                    n_oval  = '0;
                    n_ocnt  = '0;
                end
                n_first = 1'b0;
                n_held  = '0;
                n_bia   = '0;
                if (i_in_data.mode == MODE_CMD_END) begin
                    n_phase = PH_NORMAL;
                    n_oval  = '0;
                    n_ocnt  = '0;
                    n_first = 1'b1;
                    n_supp  = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/eesd_queue.sv @@
`timescale 1ns / 1ps

module eesd_queue import eesd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_bundle o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (i_push && !i_pop) r_count <= r_count + CNT_W'(1);
            else if (i_pop && !i_push) r_count <= r_count - CNT_W'(1);
        end
    end

endmodule

@@ rtl/eesd_back.sv @@
`timescale 1ns / 1ps

module eesd_back import eesd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_bundle   i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic       r_out_valid;
    t_out_item  r_out;
    logic [1:0] r_idx;
    logic       load;
    logic       is_last;

    assign load        = !r_out_valid || !i_out_stall;
    assign is_last     = (r_idx == i_head.count - 2'd1);
    assign o_pop       = load && !i_q_empty && is_last;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (load && !i_q_empty) begin
            r_out.out_byte <= i_head.bytes[r_idx];
            r_out.last     <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else if (load) begin
            r_out_valid <= !i_q_empty;
            if (!i_q_empty) r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

@@ rtl/echo_escape_stream_decoder_core.sv @@
`timescale 1ns / 1ps

// Echo output decoder. Takes one input transfer (argument byte or boundary
// mark) per cycle while the queue has room and turns it into zero to three
// output bytes, one output transfer per cycle unless the output stalls; the
// last byte of each item carries last. The front end decodes an item in the
// cycle it is accepted and posts its bytes to a QUEUE_DEPTH-entry queue;
// input stall rises only when that queue is full. Bytes pass through the
// queue entry and output register. Sustained input rate is one item per
// cycle while items average at most one output byte and output does not stall. Write
// the style and alert registers only while idle; cfg ready is always high.
module echo_escape_stream_decoder_core import eesd_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data
);

    logic    q_full;
    logic    q_empty;
    logic    q_push;
    logic    q_pop;
    t_bundle q_in;
    t_bundle q_head;

    assign o_cfg_ready = 1'b1;

    eesd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_bundle    (q_in)
    );

    eesd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (q_in),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_empty  (q_empty),
        .o_head   (q_head)
    );

    eesd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
